FILE: hdl/ngs_pkg.sv
package ngs_pkg;

  localparam int PITCH_W    = 16;
  localparam int DIM_W      = 9;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int ROW_W      = 8;
  localparam int DIV_STEP_W = 4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/ngs_table.sv
module ngs_table import ngs_pkg::*; #(
  parameter int MAX_GRIDS  = 8,
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 256,
  localparam int IDXW      = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDXW-1:0]       waddr,
  input  logic [COORD_BITS-1:0] w_ox,
  input  logic [COORD_BITS-1:0] w_oy,
  input  logic [PITCH_W-1:0]    w_sx,
  input  logic [PITCH_W-1:0]    w_sy,
  input  logic [DIM_W-1:0]      w_rows,
  input  logic [DIM_W-1:0]      w_cols,
  input  logic [IDXW-1:0]       raddr,
  output logic [COORD_BITS-1:0] r_ox,
  output logic [COORD_BITS-1:0] r_oy,
  output logic [PITCH_W-1:0]    r_sx,
  output logic [PITCH_W-1:0]    r_sy,
  output logic [DIM_W-1:0]      r_rows_m1,
  output logic [DIM_W-1:0]      r_cols_m1
);

  logic [COORD_BITS-1:0] ox_mem [MAX_GRIDS];
  logic [COORD_BITS-1:0] oy_mem [MAX_GRIDS];
  logic [PITCH_W-1:0]    sx_mem [MAX_GRIDS];
  logic [PITCH_W-1:0]    sy_mem [MAX_GRIDS];
  logic [DIM_W-1:0]      rows_mem [MAX_GRIDS];
  logic [DIM_W-1:0]      cols_mem [MAX_GRIDS];

  function automatic logic [PITCH_W-1:0] fix_pitch(input logic [PITCH_W-1:0] p);
    return (p == '0) ? PITCH_W'(1) : p;
  endfunction

  // stored as count minus one
  function automatic logic [DIM_W-1:0] fix_dim_m1(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = '0;
    end else if (32'(d) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM - 1);
    end else begin
      res = d - DIM_W'(1);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      ox_mem[waddr]   <= w_ox;
      oy_mem[waddr]   <= w_oy;
      sx_mem[waddr]   <= fix_pitch(w_sx);
      sy_mem[waddr]   <= fix_pitch(w_sy);
      rows_mem[waddr] <= fix_dim_m1(w_rows);
      cols_mem[waddr] <= fix_dim_m1(w_cols);
    end
    r_ox      <= ox_mem[raddr];
    r_oy      <= oy_mem[raddr];
    r_sx      <= sx_mem[raddr];
    r_sy      <= sy_mem[raddr];
    r_rows_m1 <= rows_mem[raddr];
    r_cols_m1 <= cols_mem[raddr];
  end

endmodule

FILE: hdl/ngs_mul.sv
module ngs_mul import ngs_pkg::*; #(
  parameter int MUL_W = 16
) (
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hdl/ngs_div.sv
module ngs_div import ngs_pkg::*; #(
  parameter int NUM_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [PITCH_W-1:0] den,
  output logic [DIM_W-1:0] quo,
  output div_stat_t        stat
);

  localparam int W = (NUM_W > PITCH_W + DIM_W) ? NUM_W : PITCH_W + DIM_W;

  logic [W-1:0]          rem_r;
  logic [W-1:0]          dsh_r;
  logic [DIM_W-1:0]      q_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic                  busy_r;
  logic                  done_r;
  logic                  ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= W'(num);
      dsh_r  <= W'(den) << (DIM_W - 1);
      q_r    <= '0;
      step_r <= DIV_STEP_W'(DIM_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r    <= {q_r[DIM_W-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - DIV_STEP_W'(1);
    end
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/nearest_grid_site_finder.sv
// nearest_grid_site_finder
// Input channel in_*: one word per item. in_kind selects a load, which writes
// grid entry in_grid_slot (origin, pitch, row and column counts), or a query
// of the point in_point_x/in_point_y. A load gives no result. A query gives
// one result word on out_*: found, the nearest grid (first one on ties) and
// the nearest row and column within it.
// Config port cfg_*: cfg_grid_count sets how many entries a query scans; it
// is taken only while the block is idle.
// A query scans the entries one at a time through a shared multiplier (table
// read, x and y spans, x and y gap squares, compare), then snaps each axis
// that lands inside the chosen grid with a serial divider of nine steps; an
// axis outside it is clamped to the edge. With no grids a query goes straight
// to the result. in_stall stays high until the result is in the output
// register, so one query is handled at a time.
// A result is held in the output register until out_stall is low; the next
// item may be accepted meanwhile, and its result waits for the register.
// Reset (rst_n low, synchronous) clears the grid count and drops any pending
// result; table contents are undefined until loaded.
module nearest_grid_site_finder import ngs_pkg::*; #(
  parameter int MAX_GRIDS  = 8,
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [SLOT_W-1:0]     in_grid_slot,
  input  logic [COORD_BITS-1:0] in_origin_x,
  input  logic [COORD_BITS-1:0] in_origin_y,
  input  logic [PITCH_W-1:0]    in_pitch_x,
  input  logic [PITCH_W-1:0]    in_pitch_y,
  input  logic [DIM_W-1:0]      in_row_total,
  input  logic [DIM_W-1:0]      in_col_total,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [SLOT_W-1:0]     out_chosen_grid,
  output logic [ROW_W-1:0]      out_site_row,
  output logic [ROW_W-1:0]      out_site_col,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_grid_count
);

  localparam int IDXW  = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;
  localparam int CW    = $clog2(MAX_GRIDS + 1);
  localparam int MUL_W = (COORD_BITS > PITCH_W) ? COORD_BITS : PITCH_W;
  localparam int SPAN_W = PITCH_W + DIM_W;
  localparam int HW    = ((COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W) + 1;
  localparam int NUM_W = MUL_W + 1;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int DW    = SQ_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_HX, S_HY, S_GX, S_GY, S_CMP,
    S_SNX, S_WX, S_SNY, S_WY, S_OUT
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r;
  logic [CW-1:0]         n_r;
  logic [CW-1:0]         idx_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [HW-1:0]         hx_r;
  logic [HW-1:0]         hy_r;
  logic [SQ_W-1:0]       sq_r;
  logic                  found_r;
  logic [DW-1:0]         best_d_r;
  logic [IDXW-1:0]       best_idx_r;
  logic [COORD_BITS-1:0] best_ox_r;
  logic [COORD_BITS-1:0] best_oy_r;
  logic [PITCH_W-1:0]    best_sx_r;
  logic [PITCH_W-1:0]    best_sy_r;
  logic [DIM_W-1:0]      best_rows_m1_r;
  logic [DIM_W-1:0]      best_cols_m1_r;
  logic [HW-1:0]         best_hx_r;
  logic [HW-1:0]         best_hy_r;
  logic [DIM_W-1:0]      row_r;
  logic [DIM_W-1:0]      col_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [SLOT_W-1:0]     out_chosen_grid_r;
  logic [ROW_W-1:0]      out_site_row_r;
  logic [ROW_W-1:0]      out_site_col_r;

  logic                  in_acc;
  logic                  tbl_we;
  logic [CW-1:0]         n_sat;
  logic [COORD_BITS-1:0] r_ox;
  logic [COORD_BITS-1:0] r_oy;
  logic [PITCH_W-1:0]    r_sx;
  logic [PITCH_W-1:0]    r_sy;
  logic [DIM_W-1:0]      r_rows_m1;
  logic [DIM_W-1:0]      r_cols_m1;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [2*MUL_W-1:0]    mul_p;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [DW-1:0]         sq_sum;
  logic                  x_above;
  logic                  x_below;
  logic                  y_above;
  logic                  y_below;
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [PITCH_W-1:0]    div_den;
  logic [DIM_W-1:0]      div_q;
  div_stat_t             div_stat;

  function automatic logic [COORD_BITS-1:0] axis_gap(
    input logic [COORD_BITS-1:0] p,
    input logic [COORD_BITS-1:0] lo,
    input logic [HW-1:0]         hi
  );
    logic [COORD_BITS-1:0] res;
    if (p < lo) begin
      res = lo - p;
    end else if (HW'(p) > hi) begin
      res = COORD_BITS'(HW'(p) - hi);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign tbl_we    = in_acc && (in_kind == KIND_LOAD) && (32'(in_grid_slot) < MAX_GRIDS);
  assign n_sat     = (32'(count_r) > MAX_GRIDS) ? CW'(MAX_GRIDS) : CW'(count_r);

  ngs_table #(
    .MAX_GRIDS (MAX_GRIDS),
    .COORD_BITS(COORD_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_table (
    .clk      (clk),
    .we       (tbl_we),
    .waddr    (IDXW'(in_grid_slot)),
    .w_ox     (in_origin_x),
    .w_oy     (in_origin_y),
    .w_sx     (in_pitch_x),
    .w_sy     (in_pitch_y),
    .w_rows   (in_row_total),
    .w_cols   (in_col_total),
    .raddr    (idx_r[IDXW-1:0]),
    .r_ox     (r_ox),
    .r_oy     (r_oy),
    .r_sx     (r_sx),
    .r_sy     (r_sy),
    .r_rows_m1(r_rows_m1),
    .r_cols_m1(r_cols_m1)
  );

  assign dx     = axis_gap(px_r, r_ox, hx_r);
  assign dy     = axis_gap(py_r, r_oy, hy_r);
  assign sq_sum = DW'(sq_r) + DW'(mul_p[SQ_W-1:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HX: begin
        mul_a = MUL_W'(r_cols_m1);
        mul_b = MUL_W'(r_sx);
      end
      S_HY: begin
        mul_a = MUL_W'(r_rows_m1);
        mul_b = MUL_W'(r_sy);
      end
      S_GX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      S_GY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ngs_mul #(.MUL_W(MUL_W)) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  assign x_above = HW'(px_r) > best_hx_r;
  assign x_below = px_r < best_ox_r;
  assign y_above = HW'(py_r) > best_hy_r;
  assign y_below = py_r < best_oy_r;

  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(px_r) - NUM_W'(best_ox_r) + NUM_W'(best_sx_r >> 1);
    div_den   = best_sx_r;
    if (state_r == S_SNX) begin
      div_start = !x_above && !x_below;
    end else if (state_r == S_SNY) begin
      div_start = !y_above && !y_below;
      div_num   = NUM_W'(py_r) - NUM_W'(best_oy_r) + NUM_W'(best_sy_r >> 1);
      div_den   = best_sy_r;
    end
  end

  ngs_div #(.NUM_W(NUM_W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_q),
    .stat (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_grid_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_kind == KIND_QUERY) begin
            px_r       <= in_point_x;
            py_r       <= in_point_y;
            n_r        <= n_sat;
            idx_r      <= '0;
            found_r    <= (n_sat != '0);
            best_idx_r <= '0;
            row_r      <= '0;
            col_r      <= '0;
            state_r    <= (n_sat == '0) ? S_OUT : S_RD;
          end
        end
        S_RD: state_r <= S_HX;
        S_HX: state_r <= S_HY;
        S_HY: begin
          hx_r    <= HW'(r_ox) + HW'(mul_p[SPAN_W-1:0]);
          state_r <= S_GX;
        end
        S_GX: begin
          hy_r    <= HW'(r_oy) + HW'(mul_p[SPAN_W-1:0]);
          state_r <= S_GY;
        end
        S_GY: begin
          sq_r    <= mul_p[SQ_W-1:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (idx_r == '0 || sq_sum < best_d_r) begin
            best_d_r       <= sq_sum;
            best_idx_r     <= idx_r[IDXW-1:0];
            best_ox_r      <= r_ox;
            best_oy_r      <= r_oy;
            best_sx_r      <= r_sx;
            best_sy_r      <= r_sy;
            best_rows_m1_r <= r_rows_m1;
            best_cols_m1_r <= r_cols_m1;
            best_hx_r      <= hx_r;
            best_hy_r      <= hy_r;
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= (idx_r + CW'(1) == n_r) ? S_SNX : S_RD;
        end
        S_SNX: begin
          if (x_above) begin
            col_r   <= best_cols_m1_r;
            state_r <= S_SNY;
          end else if (x_below) begin
            col_r   <= '0;
            state_r <= S_SNY;
          end else begin
            state_r <= S_WX;
          end
        end
        S_WX: begin
          if (div_stat.done) begin
            col_r   <= div_q;
            state_r <= S_SNY;
          end
        end
        S_SNY: begin
          if (y_above) begin
            row_r   <= best_rows_m1_r;
            state_r <= S_OUT;
          end else if (y_below) begin
            row_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_WY;
          end
        end
        S_WY: begin
          if (div_stat.done) begin
            row_r   <= div_q;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_found_r       <= found_r;
            out_chosen_grid_r <= SLOT_W'(best_idx_r);
            out_site_row_r    <= row_r[ROW_W-1:0];
            out_site_col_r    <= col_r[ROW_W-1:0];
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_grid = out_chosen_grid_r;
  assign out_site_row    = out_site_row_r;
  assign out_site_col    = out_site_col_r;

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_chosen_grid == '0 && out_site_row == '0 &&
                                out_site_col == '0)
    else $error("no-grid result carries nonzero fields");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_WX || state_r == S_WY))
    else $error("divider finished outside a wait state");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> idx_r < n_r)
    else $error("scan index past grid count");

endmodule
